// ===== hw/rtl/slid_pkg.sv =====
// ----------------------------------------------------------------------------
// slid_pkg
// Shared types, codes and sizes for the sorted list block.
// ----------------------------------------------------------------------------
package slid_pkg;

  // Default list depth
  localparam int CAPACITY = 16;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  // Cell operations, broadcast along the row
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_ROTATE = 2'd3;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Broadcast to every cell
  typedef struct packed {
    logic [1:0] op;
    value_t     value;
  } cell_ctrl_t;

  // What a cell shows its right-hand neighbor
  typedef struct packed {
    value_t value;
    logic   lt;
    logic   eq;
  } cell_link_t;

  // Row summary handed to the controller
  typedef struct packed {
    value_t           head;
    logic [POS_W-1:0] ins_pos;
    logic [POS_W-1:0] del_pos;
    logic             del_found;
  } chain_stat_t;

endpackage

// ===== hw/rtl/slid_req_if.sv =====
// ----------------------------------------------------------------------------
// slid_req_if
// Command channel: valid/ready handshake with command and value.
// ----------------------------------------------------------------------------
interface slid_req_if;
  logic                              valid;
  logic                              ready;
  logic [slid_pkg::CMD_W-1:0]        command;
  logic signed [slid_pkg::VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== hw/rtl/slid_rsp_if.sv =====
// ----------------------------------------------------------------------------
// slid_rsp_if
// Result channel: valid/ready handshake with value, position, status, last.
// ----------------------------------------------------------------------------
interface slid_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [slid_pkg::VALUE_W-1:0] value_out;
  logic [slid_pkg::POS_W-1:0]          position;
  logic [slid_pkg::STATUS_W-1:0]       status;
  logic                                last;

  modport source (output valid, output value_out, output position, output status,
                  output last, input ready);
  modport sink   (input valid, input value_out, input position, input status,
                  input last, output ready);
endinterface

// ===== hw/rtl/sorted_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Sorted list of signed 32-bit values with insert, delete and dump.
// ----------------------------------------------------------------------------
// Commands arrive on req (command, value) and results leave on rsp
// (value_out, position, status, last), both valid/ready channels.
// Insert and delete are decided and applied in the cycle the word is taken:
// every cell compares against the value in parallel and shifts one place.
// Their single result is in the output register in the next cycle, and a new
// command can be taken every cycle while rsp keeps up.
// A dump of N entries rotates the cell row one place per cycle while rsp
// keeps up, giving one result per cycle from the head cell, and req is held
// off until its final result is loaded. Empty dump gives one status word.
// Command code 3 is taken and dropped with no result.
// Reset clears the entry count, the output valid flag and the dump sequencer;
// cell contents are left as they are and are never read while unoccupied.
// When rsp stalls, the output register holds and req.ready drops until
// the waiting result is taken.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete #(
  parameter int CAPACITY = slid_pkg::CAPACITY
) (
  input logic       clk,
  input logic       rst,
  slid_req_if.sink  req,
  slid_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = slid_pkg::POS_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic                  state;
  logic                  state_next;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         remain;
  logic [CW-1:0]         remain_next;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         idx_next;
  logic [IW+PW-1:0]      idx_ext;

  logic                          out_valid;
  slid_pkg::value_t              value_out;
  logic [PW-1:0]                 position;
  logic [slid_pkg::STATUS_W-1:0] status;
  logic                          last;

  logic                          load;
  slid_pkg::value_t              res_value;
  logic [PW-1:0]                 res_pos;
  logic [slid_pkg::STATUS_W-1:0] res_status;
  logic                          res_last;

  logic                  out_free;
  logic                  accept;
  logic                  full;
  logic                  empty;
  slid_pkg::cell_ctrl_t  ctrl;
  slid_pkg::chain_stat_t stat;

  slid_chain #(
    .CAPACITY(CAPACITY)
  ) u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .count(count),
    .stat (stat)
  );

  // Handshake
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign full      = count == CW'(CAPACITY);
  assign empty     = count == '0;
  assign idx_ext   = {{PW{1'b0}}, idx};

  // Command decode and dump sequencing
  always_comb begin
    ctrl.op     = slid_pkg::OP_HOLD;
    ctrl.value  = req.value;
    load        = 1'b0;
    res_value   = req.value;
    res_pos     = '0;
    res_status  = slid_pkg::ST_OK;
    res_last    = 1'b1;
    count_next  = count;
    state_next  = state;
    remain_next = remain;
    idx_next    = idx;
    if (state == S_IDLE) begin
      if (accept) begin
        case (req.command)
          slid_pkg::CMD_INSERT: begin
            load = 1'b1;
            if (full) begin
              res_status = slid_pkg::ST_FULL;
            end else begin
              ctrl.op    = slid_pkg::OP_INSERT;
              res_pos    = stat.ins_pos;
              count_next = count + 1'b1;
            end
          end
          slid_pkg::CMD_DELETE: begin
            load = 1'b1;
            if (empty) begin
              res_status = slid_pkg::ST_EMPTY;
            end else if (!stat.del_found) begin
              res_status = slid_pkg::ST_NOT_FOUND;
            end else begin
              ctrl.op    = slid_pkg::OP_DELETE;
              res_pos    = stat.del_pos;
              count_next = count - 1'b1;
            end
          end
          slid_pkg::CMD_DUMP: begin
            if (empty) begin
              load       = 1'b1;
              res_status = slid_pkg::ST_EMPTY;
            end else begin
              state_next  = S_DUMP;
              remain_next = count;
              idx_next    = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (out_free) begin
      // stream the head cell, then rotate the occupied cells left
      load        = 1'b1;
      ctrl.op     = slid_pkg::OP_ROTATE;
      res_value   = stat.head;
      res_pos     = idx_ext[PW-1:0];
      res_last    = remain == CW'(1);
      remain_next = remain - 1'b1;
      idx_next    = idx + 1'b1;
      if (res_last) begin
        state_next = S_IDLE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remain    <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
      idx    <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (load) begin
      value_out <= res_value;
      position  <= res_pos;
      status    <= res_status;
      last      <= res_last;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.value_out = value_out;
  assign rsp.position  = position;
  assign rsp.status    = status;
  assign rsp.last      = last;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_dump_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> !req.ready)
    else $error("command taken during dump");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == slid_pkg::CMD_INSERT && !full)
      |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the list");

  a_dump_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP && out_free && remain == CW'(1)) |=> state == S_IDLE && rsp.last)
    else $error("dump did not end on its final word");

endmodule

// ===== hw/rtl/slid_cell.sv =====
// ----------------------------------------------------------------------------
// slid_cell
// One list entry: compares against the broadcast value and takes its own, its
// left or right neighbor's, the broadcast or the head word on insert/delete/rotate.
// ----------------------------------------------------------------------------
module slid_cell (
  input  logic                 clk,
  input  slid_pkg::cell_ctrl_t ctrl,
  input  logic                 occupied,
  input  logic                 is_tail,
  input  slid_pkg::cell_link_t left,
  input  slid_pkg::value_t     right_value,
  input  slid_pkg::value_t     head_value,
  output slid_pkg::cell_link_t link
);

  slid_pkg::value_t stored;
  slid_pkg::value_t stored_next;
  logic             lt;
  logic             eq;

  // Compare against the broadcast value
  assign lt = occupied && (stored < ctrl.value);
  assign eq = occupied && (stored == ctrl.value);

  assign link.value = stored;
  assign link.lt    = lt;
  assign link.eq    = eq;

  // Pick the next word
  always_comb begin
    stored_next = stored;
    case (ctrl.op)
      slid_pkg::OP_INSERT: begin
        if (lt) begin
          stored_next = stored;
        end else if (left.lt) begin
          stored_next = ctrl.value;
        end else begin
          stored_next = left.value;
        end
      end
      slid_pkg::OP_DELETE: begin
        // cells from the removed entry onward pull from the right
        if (!lt) begin
          stored_next = right_value;
        end
      end
      slid_pkg::OP_ROTATE: begin
        stored_next = is_tail ? head_value : right_value;
      end
      default: begin
        stored_next = stored;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    stored <= stored_next;
  end

endmodule

// ===== hw/rtl/slid_chain.sv =====
// ----------------------------------------------------------------------------
// slid_chain
// Row of list cells with neighbor links, plus insert and delete position
// encoders over the row.
// ----------------------------------------------------------------------------
module slid_chain #(
  parameter int CAPACITY = slid_pkg::CAPACITY
) (
  input  logic                          clk,
  input  slid_pkg::cell_ctrl_t          ctrl,
  input  logic [$clog2(CAPACITY+1)-1:0] count,
  output slid_pkg::chain_stat_t         stat
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  slid_pkg::cell_link_t links [CAPACITY];
  slid_pkg::cell_link_t lefts [CAPACITY];
  slid_pkg::value_t     rights[CAPACITY];
  logic [CAPACITY-1:0]  occ;
  logic [CAPACITY-1:0]  tail;
  logic [CAPACITY-1:0]  ins_hot;
  logic [CAPACITY-1:0]  del_hot;
  logic [IW-1:0]        ins_idx;
  logic [IW-1:0]        del_idx;
  logic [IW+slid_pkg::POS_W-1:0] ins_ext;
  logic [IW+slid_pkg::POS_W-1:0] del_ext;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      assign occ[i]  = count > CW'(i);
      assign tail[i] = count == CW'(i + 1);

      // Neighbor links; the head sees "everything before is smaller"
      if (i == 0) begin : g_head
        assign lefts[i].value = ctrl.value;
        assign lefts[i].lt    = 1'b1;
        assign lefts[i].eq    = 1'b0;
      end else begin : g_body
        assign lefts[i] = links[i-1];
      end
      if (i == CAPACITY - 1) begin : g_end
        assign rights[i] = links[i].value;
      end else begin : g_mid
        assign rights[i] = links[i+1].value;
      end

      // Insert goes where smaller stops; delete hits the first equal entry
      assign ins_hot[i] = !links[i].lt && lefts[i].lt;
      assign del_hot[i] = links[i].eq && !lefts[i].eq;

      slid_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occ[i]),
        .is_tail    (tail[i]),
        .left       (lefts[i]),
        .right_value(rights[i]),
        .head_value (links[0].value),
        .link       (links[i])
      );
    end
  endgenerate

  // One-hot to index
  always_comb begin
    ins_idx = '0;
    del_idx = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      ins_idx = ins_idx | (ins_hot[k] ? IW'(k) : '0);
      del_idx = del_idx | (del_hot[k] ? IW'(k) : '0);
    end
  end

  assign ins_ext = {{slid_pkg::POS_W{1'b0}}, ins_idx};
  assign del_ext = {{slid_pkg::POS_W{1'b0}}, del_idx};

  assign stat.head      = links[0].value;
  assign stat.ins_pos   = ins_ext[slid_pkg::POS_W-1:0];
  assign stat.del_pos   = del_ext[slid_pkg::POS_W-1:0];
  assign stat.del_found = |del_hot;

endmodule
